// ===== src/dtp_pkg.sv =====
package dtp_pkg;

  // result status codes, lowest value wins when several conditions hold
  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_EMPTY = 3'd1,
    ST_DOT   = 3'd2,
    ST_BAD   = 3'd3,
    ST_OVF   = 3'd4
  } status_t;

  // parser phase, one-hot
  typedef enum logic [4:0] {
    PH_LEAD   = 5'b00001,
    PH_DIGITS = 5'b00010,
    PH_GAP    = 5'b00100,
    PH_UNIT   = 5'b01000,
    PH_TRAIL  = 5'b10000
  } phase_t;

  localparam int TOTAL_W = 63;
  localparam int WIDE_W  = TOTAL_W + 4;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_Z  = 8'h7A;

  // letter run length saturates here, no known unit is that long
  localparam logic [2:0] ULEN_MAX = 3'd4;

  // y, mon, w, d, h, min, s, ms, us
  localparam int NUM_UNITS = 9;

  localparam logic [23:0] UNIT_KEY [NUM_UNITS] = '{
    24'h000079, 24'h6D6F6E, 24'h000077, 24'h000064, 24'h000068,
    24'h6D696E, 24'h000073, 24'h006D73, 24'h007573
  };

  localparam logic [2:0] UNIT_NCHAR [NUM_UNITS] = '{
    3'd1, 3'd3, 3'd1, 3'd1, 3'd1, 3'd3, 3'd1, 3'd2, 3'd2
  };

  // unit length = ticks_per_second * seconds / divisor, truncated
  localparam logic [31:0] UNIT_SEC [NUM_UNITS] = '{
    32'd31556952, 32'd2629746, 32'd604800, 32'd86400, 32'd3600,
    32'd60, 32'd1, 32'd1, 32'd1
  };

  localparam logic [31:0] UNIT_DIV [NUM_UNITS] = '{
    32'd1, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1000, 32'd1000000
  };

  // base * 10 + addend, wide enough to see any carry past 63 bits
  function automatic logic [WIDE_W-1:0] mac10(input logic [TOTAL_W-1:0] base,
                                              input logic [TOTAL_W-1:0] addend);
    logic [WIDE_W-1:0] b;
    b = {4'b0, base};
    return (b << 3) + (b << 1) + {4'b0, addend};
  endfunction

endpackage

// ===== src/duration_text_parser.sv =====
// channel  | ports                                   | direction
// ---------+-----------------------------------------+----------
// in       | in_valid in_stall in_char_code in_is_end | consumed
// out      | out_valid out_stall out_total_micros     | produced
//          | out_status                              |
//
// one item per cycle, except an end item, which waits while the output register is full and stalled
// each digit updates the amount and one product lane per unit in parallel,
// so a unit is priced by lane selection plus one 63-bit add at the term end
// a result appears in the output register the cycle after its end item
// rst_n is synchronous, active low, and returns the parser to leading-space skip
// characters keep flowing while a result waits; only an end item stalls
// when the output register is full and stalled
module duration_text_parser #(
  parameter int TICKS_PER_SECOND = 1000000
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_char_code,
  input  logic              in_is_end,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [62:0]       out_total_micros,
  output dtp_pkg::status_t  out_status
);
  import dtp_pkg::*;

  // parser state
  phase_t               phase_r, phase_nxt;
  logic [TOTAL_W-1:0]   amount_r;
  logic [23:0]          letters_r, letters_nxt;
  logic [2:0]           ulen_r, ulen_nxt;
  logic [TOTAL_W-1:0]   total_r, total_nxt;
  logic                 dot_r, dot_nxt;
  logic                 bad_r, bad_nxt;
  logic                 ovf_r, ovf_nxt;
  logic                 content_r, content_nxt;

  // amount times each unit length, kept up to date digit by digit
  logic [TOTAL_W-1:0]   lane_r [NUM_UNITS];
  logic [NUM_UNITS-1:0] lane_ovf_r;

  // output register
  logic                 out_valid_r;
  logic [TOTAL_W-1:0]   out_total_r;
  status_t              out_status_r;

  logic                 in_acc;
  logic                 is_sp, is_dg, is_lw, is_dot;
  logic                 digit_en;
  logic [TOTAL_W-1:0]   amt_add;
  logic [WIDE_W-1:0]    amt_wide;
  logic                 amt_ovf;

  logic [NUM_UNITS-1:0] unit_hit;
  logic                 unit_known;
  logic [TOTAL_W-1:0]   prod;
  logic                 prod_ovf;
  logic [TOTAL_W:0]     sum;
  logic                 sum_ovf;

  logic                 end_bad, end_ovf;
  logic [TOTAL_W-1:0]   end_total;
  status_t              end_status;

  // an end item needs the output register, characters never do
  assign in_stall = out_valid_r & out_stall & in_is_end;
  assign in_acc   = in_valid & ~in_stall;

  // character classes
  assign is_sp  = (in_char_code == CH_SPACE) ||
                  ((in_char_code >= CH_TAB) && (in_char_code <= CH_CR));
  assign is_dg  = (in_char_code >= CH_ZERO) && (in_char_code <= CH_NINE);
  assign is_lw  = (in_char_code >= CH_LOW_A) && (in_char_code <= CH_LOW_Z);
  assign is_dot = (in_char_code == CH_DOT);

  // amount: start from zero unless already inside a digit run
  assign amt_add  = {59'b0, in_char_code[3:0]};
  assign amt_wide = mac10((phase_r == PH_DIGITS) ? amount_r : '0, amt_add);
  assign amt_ovf  = |amt_wide[WIDE_W-1:TOTAL_W];

  always_ff @(posedge clk) begin
    if (digit_en) begin
      amount_r <= amt_wide[TOTAL_W-1:0];
    end
  end

  // one product lane per unit; a lane overflow only matters if its unit is chosen
  for (genvar u = 0; u < NUM_UNITS; u++) begin : g_lane
    localparam logic [TOTAL_W-1:0] LEN =
      (TOTAL_W'(TICKS_PER_SECOND) * TOTAL_W'(UNIT_SEC[u])) / TOTAL_W'(UNIT_DIV[u]);

    logic [TOTAL_W-1:0] dmul;
    logic [WIDE_W-1:0]  wide;
    logic               ovf_keep;

    assign dmul     = TOTAL_W'(in_char_code[3:0]) * LEN;
    assign wide     = mac10((phase_r == PH_DIGITS) ? lane_r[u] : '0, dmul);
    assign ovf_keep = (phase_r == PH_DIGITS) & lane_ovf_r[u];

    always_ff @(posedge clk) begin
      if (digit_en) begin
        lane_r[u]     <= wide[TOTAL_W-1:0];
        lane_ovf_r[u] <= ovf_keep | (|wide[WIDE_W-1:TOTAL_W]);
      end
    end

    assign unit_hit[u] = (ulen_r == UNIT_NCHAR[u]) && (letters_r == UNIT_KEY[u]);
  end

  // close a term: pick the lane of the named unit and add it to the total
  always_comb begin
    prod     = '0;
    prod_ovf = 1'b0;
    for (int u = 0; u < NUM_UNITS; u++) begin
      if (unit_hit[u]) begin
        prod     = prod | lane_r[u];
        prod_ovf = prod_ovf | lane_ovf_r[u];
      end
    end
  end

  assign unit_known = |unit_hit;
  assign sum        = {1'b0, total_r} + {1'b0, prod};
  assign sum_ovf    = sum[TOTAL_W];

  // what the end item reports
  always_comb begin
    end_bad   = bad_r;
    end_ovf   = ovf_r;
    end_total = total_r;
    if (!bad_r) begin
      if ((phase_r == PH_DIGITS) || (phase_r == PH_GAP)) begin
        end_bad = 1'b1;
      end else if (phase_r == PH_UNIT) begin
        if (!unit_known) begin
          end_bad = 1'b1;
        end else begin
          end_ovf   = ovf_r | prod_ovf | sum_ovf;
          end_total = sum[TOTAL_W-1:0];
        end
      end
    end
    if (!content_r) begin
      end_status = ST_EMPTY;
    end else if (dot_r) begin
      end_status = ST_DOT;
    end else if (end_bad) begin
      end_status = ST_BAD;
    end else if (end_ovf) begin
      end_status = ST_OVF;
    end else begin
      end_status = ST_OK;
    end
  end

  // character handling
  always_comb begin
    phase_nxt   = phase_r;
    letters_nxt = letters_r;
    ulen_nxt    = ulen_r;
    total_nxt   = total_r;
    dot_nxt     = dot_r;
    bad_nxt     = bad_r;
    ovf_nxt     = ovf_r;
    content_nxt = content_r;
    digit_en    = 1'b0;

    if (in_acc) begin
      if (in_is_end) begin
        // back to the reset state for the next text
        phase_nxt   = PH_LEAD;
        total_nxt   = '0;
        dot_nxt     = 1'b0;
        bad_nxt     = 1'b0;
        ovf_nxt     = 1'b0;
        content_nxt = 1'b0;
      end else begin
        if (is_dot) begin
          dot_nxt = 1'b1;
        end
        if (!((phase_r == PH_LEAD) && is_sp)) begin
          content_nxt = 1'b1;
          // once malformed only dots are still watched
          if (!bad_r) begin
            unique case (phase_r)
              PH_LEAD, PH_TRAIL: begin
                if (is_dg) begin
                  digit_en  = 1'b1;
                  phase_nxt = PH_DIGITS;
                end else if (!is_sp) begin
                  bad_nxt = 1'b1;
                end
              end
              PH_DIGITS: begin
                if (is_dg) begin
                  digit_en = 1'b1;
                  if (amt_ovf) begin
                    ovf_nxt = 1'b1;
                  end
                end else if (is_sp) begin
                  phase_nxt = PH_GAP;
                end else if (is_lw) begin
                  letters_nxt = {16'b0, in_char_code};
                  ulen_nxt    = 3'd1;
                  phase_nxt   = PH_UNIT;
                end else begin
                  bad_nxt = 1'b1;
                end
              end
              PH_GAP: begin
                if (is_lw) begin
                  letters_nxt = {16'b0, in_char_code};
                  ulen_nxt    = 3'd1;
                  phase_nxt   = PH_UNIT;
                end else if (!is_sp) begin
                  bad_nxt = 1'b1;
                end
              end
              PH_UNIT: begin
                if (is_lw) begin
                  letters_nxt = {letters_r[15:0], in_char_code};
                  if (ulen_r != ULEN_MAX) begin
                    ulen_nxt = ulen_r + 3'd1;
                  end
                end else if (!unit_known) begin
                  bad_nxt = 1'b1;
                end else begin
                  total_nxt = sum[TOTAL_W-1:0];
                  if (prod_ovf || sum_ovf) begin
                    ovf_nxt = 1'b1;
                  end
                  if (is_sp) begin
                    phase_nxt = PH_TRAIL;
                  end else if (is_dg) begin
                    digit_en  = 1'b1;
                    phase_nxt = PH_DIGITS;
                  end else begin
                    bad_nxt = 1'b1;
                  end
                end
              end
              default: begin
                bad_nxt = 1'b1;
              end
            endcase
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_LEAD;
      total_r   <= '0;
      dot_r     <= 1'b0;
      bad_r     <= 1'b0;
      ovf_r     <= 1'b0;
      content_r <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      total_r   <= total_nxt;
      dot_r     <= dot_nxt;
      bad_r     <= bad_nxt;
      ovf_r     <= ovf_nxt;
      content_r <= content_nxt;
    end
  end

  // letters are loaded before any read
  always_ff @(posedge clk) begin
    letters_r <= letters_nxt;
    ulen_r    <= ulen_nxt;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc && in_is_end) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_is_end) begin
      out_status_r <= end_status;
      out_total_r  <= (end_status == ST_OK) ? end_total : '0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_total_micros = out_total_r;
  assign out_status       = out_status_r;

  // an accepted end item always shows up at the output next cycle
  a_end_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_is_end) |=> out_valid)
    else $error("end item did not produce a result");

  // after an end item the parser is back at leading-space skip with no total
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_is_end) |=> (phase_r == PH_LEAD) && (total_r == '0) && !content_r)
    else $error("parser state not cleared after end item");

  // a failing status never carries a total
  a_zero_total: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_OK)) |-> (out_total_micros == '0))
    else $error("nonzero total with failing status");

  // input only backs up behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a held result");

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dtp_pkg::*;

  // tick rate used by both the block and the predictor
  localparam int          TICKS        = 1000000;
  localparam logic [63:0] TPS          = 64'(TICKS);
  localparam logic [63:0] MAX_TOTAL    = 64'h7FFF_FFFF_FFFF_FFFF;
  // quiet cycles allowed before the run is declared hung
  localparam int          QUIET_LIMIT  = 5000;
  // long receiver hold used to fill the block and stall its input
  localparam int          HOLD_CYCLES  = 400;
  // settle time after the last result, a result comes the cycle after its end item is accepted
  localparam int          DRAIN_CYCLES = 20;
  // rough number of characters per idling phase of the random part
  localparam int          PHASE_CHARS  = 30;

  typedef struct {
    logic [62:0] total;
    status_t     status;
  } duration_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_char_code;
  logic        in_is_end;
  logic        out_valid;
  logic        out_stall;
  logic [62:0] out_total_micros;
  status_t     out_status;

  // durations still owed by the block, oldest first
  duration_result_t pending_results[$];
  duration_result_t got_result;

  // parser state mirrored by the predictor
  phase_t      prs_phase;
  logic [63:0] prs_amount;
  logic [23:0] prs_letters;
  logic [2:0]  prs_nletters;
  logic [63:0] prs_total;
  logic        prs_dot;
  logic        prs_bad;
  logic        prs_ovf;
  logic        prs_content;

  // idling knobs, percent of cycles
  int unsigned send_idle_pct;
  int unsigned stall_pct;
  int unsigned chars_sent;
  int          fail_count;
  int          quiet_cycles;
  bit          hold_request;

  string unit_text [9] = '{"y", "mon", "w", "d", "h", "min", "s", "ms", "us"};

  duration_text_parser #(
    .TICKS_PER_SECOND(TICKS)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_char_code     (in_char_code),
    .in_is_end        (in_is_end),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_total_micros (out_total_micros),
    .out_status       (out_status)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // duration predictor
  // ---------------------------------------------------------------------------

  function automatic logic is_blank(input logic [7:0] ch);
    return ch == 8'h20 || (ch >= 8'h09 && ch <= 8'h0D);
  endfunction

  function automatic logic is_numeral(input logic [7:0] ch);
    return ch >= 8'h30 && ch <= 8'h39;
  endfunction

  function automatic logic is_letter(input logic [7:0] ch);
    return ch >= 8'h61 && ch <= 8'h7A;
  endfunction

  function automatic void clear_parser();
    prs_phase    = PH_LEAD;
    prs_amount   = '0;
    prs_letters  = '0;
    prs_nletters = '0;
    prs_total    = '0;
    prs_dot      = 1'b0;
    prs_bad      = 1'b0;
    prs_ovf      = 1'b0;
    prs_content  = 1'b0;
  endfunction

  function automatic void begin_amount(input logic [7:0] ch);
    prs_amount = 64'(ch - 8'h30);
    prs_phase  = PH_DIGITS;
  endfunction

  function automatic void begin_unit(input logic [7:0] ch);
    prs_letters  = {16'h0, ch};
    prs_nletters = 3'd1;
    prs_phase    = PH_UNIT;
  endfunction

  // price the letter run and add the term, saturating on overflow; an unknown unit marks the text malformed
  function automatic void close_term();
    logic [63:0] len;
    logic [63:0] prod;
    logic        known;
    known = 1'b1;
    len   = '0;
    case ({prs_nletters, prs_letters})
      {3'd1, 16'h0, "y"}: len = 64'd31556952 * TPS;
      {3'd1, 16'h0, "w"}: len = 64'd604800 * TPS;
      {3'd1, 16'h0, "d"}: len = 64'd86400 * TPS;
      {3'd1, 16'h0, "h"}: len = 64'd3600 * TPS;
      {3'd1, 16'h0, "s"}: len = TPS;
      {3'd2, 8'h0, "ms"}: len = TPS / 64'd1000;
      {3'd2, 8'h0, "us"}: len = TPS / 64'd1000000;
      {3'd3, "mon"}:      len = 64'd2629746 * TPS;
      {3'd3, "min"}:      len = 64'd60 * TPS;
      default:            known = 1'b0;
    endcase
    if (!known) begin
      prs_bad = 1'b1;
      return;
    end
    if (len != 0 && prs_amount > MAX_TOTAL / len) begin
      prod    = MAX_TOTAL;
      prs_ovf = 1'b1;
    end else begin
      prod = prs_amount * len;
    end
    if (prs_total > MAX_TOTAL - prod) begin
      prs_total = MAX_TOTAL;
      prs_ovf   = 1'b1;
    end else begin
      prs_total = prs_total + prod;
    end
  endfunction

  // advance the mirrored parser by one accepted item
  function automatic void predict_item(input logic [7:0] ch, input logic fin);
    duration_result_t res;
    logic [63:0]      digit;
    if (fin) begin
      // an open term is either malformed or gets priced now
      if (!prs_bad) begin
        if (prs_phase == PH_DIGITS || prs_phase == PH_GAP) begin
          prs_bad = 1'b1;
        end else if (prs_phase == PH_UNIT) begin
          close_term();
        end
      end
      if (!prs_content)  res.status = ST_EMPTY;
      else if (prs_dot)  res.status = ST_DOT;
      else if (prs_bad)  res.status = ST_BAD;
      else if (prs_ovf)  res.status = ST_OVF;
      else               res.status = ST_OK;
      res.total = (res.status == ST_OK) ? prs_total[62:0] : '0;
      pending_results.push_back(res);
      clear_parser();
      return;
    end
    // a dot anywhere wins over everything but an empty text
    if (ch == CH_DOT) prs_dot = 1'b1;
    if (prs_phase == PH_LEAD && is_blank(ch)) return;
    prs_content = 1'b1;
    // once malformed only dots matter
    if (prs_bad) return;
    case (prs_phase)
      PH_LEAD, PH_TRAIL: begin
        if (is_numeral(ch)) begin_amount(ch);
        else if (!is_blank(ch)) prs_bad = 1'b1;
      end
      PH_DIGITS: begin
        if (is_numeral(ch)) begin
          digit = 64'(ch - 8'h30);
          if (prs_amount > (MAX_TOTAL - digit) / 64'd10) begin
            prs_amount = MAX_TOTAL;
            prs_ovf    = 1'b1;
          end else begin
            prs_amount = prs_amount * 64'd10 + digit;
          end
        end else if (is_blank(ch)) begin
          prs_phase = PH_GAP;
        end else if (is_letter(ch)) begin
          begin_unit(ch);
        end else begin
          prs_bad = 1'b1;
        end
      end
      PH_GAP: begin
        if (is_letter(ch)) begin_unit(ch);
        else if (!is_blank(ch)) prs_bad = 1'b1;
      end
      default: begin
        if (is_letter(ch)) begin
          // keep the last three letters, count saturates past any known unit
          prs_letters = {prs_letters[15:0], ch};
          if (prs_nletters < 3'd4) prs_nletters = prs_nletters + 3'd1;
        end else begin
          close_term();
          if (!prs_bad) begin
            if (is_blank(ch)) prs_phase = PH_TRAIL;
            else if (is_numeral(ch)) begin_amount(ch);
            else prs_bad = 1'b1;
          end
        end
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // monitors, all sampling at the rising edge
  // ---------------------------------------------------------------------------

  // every accepted input item feeds the predictor
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) predict_item(in_char_code, in_is_end);
  end

  // every accepted result is matched against the oldest pending duration
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: total_micros %0d status %0d",
               out_total_micros, out_status);
        fail_count++;
      end else begin
        got_result = pending_results.pop_front();
        if (out_total_micros !== got_result.total) begin
          $error("total_micros mismatch: expected %0d actual %0d",
                 got_result.total, out_total_micros);
          fail_count++;
        end
        if (out_status !== got_result.status) begin
          $error("status mismatch: expected %0d actual %0d",
                 got_result.status, out_status);
          fail_count++;
        end
      end
    end
  end

  // hang detector: cycles with no handshake on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: random stalls, or one long hold when a test asks for it
  // ---------------------------------------------------------------------------

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        // hold counted here so the sender keeps pushing meanwhile
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------

  // called at a falling edge, returns at the falling edge after acceptance
  // valid stays high on return so back-to-back items need no toggle
  task automatic send_item(input logic [7:0] ch, input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_char_code <= ch;
    in_is_end    <= fin;
    do @(posedge clk); while (in_stall);
    if (!fin) chars_sent++;
    @(negedge clk);
  endtask

  task automatic sender_idle();
    in_valid <= 1'b0;
    @(negedge clk);
  endtask

  // one text followed by its end item, end carries a junk character
  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
    send_item(8'($urandom_range(255)), 1'b1);
  endtask

  function automatic logic [7:0] pick_blank();
    if ($urandom_range(1)) return 8'h20;
    return 8'(8'h09 + $urandom_range(4));
  endfunction

  // well-formed duration text with random terms, sometimes damaged
  task automatic send_random_text(input int unsigned flaw_pct);
    logic [7:0]  txt[$];
    int unsigned nterms;
    int unsigned ndig;
    int unsigned u;
    int unsigned pos;
    repeat ($urandom_range(2)) txt.push_back(pick_blank());
    // a few texts carry no term at all
    nterms = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 4);
    repeat (nterms) begin
      // long digit runs can reach amount saturation
      ndig = ($urandom_range(7) == 0) ? $urandom_range(10, 21) : $urandom_range(1, 4);
      repeat (ndig) txt.push_back(8'(8'h30 + $urandom_range(9)));
      repeat ($urandom_range(1)) txt.push_back(pick_blank());
      u = $urandom_range(8);
      for (int i = 0; i < unit_text[u].len(); i++) txt.push_back(unit_text[u][i]);
      repeat ($urandom_range(2)) txt.push_back(pick_blank());
    end
    if ($urandom_range(99) < flaw_pct && txt.size() > 0) begin
      pos = $urandom_range(txt.size() - 1);
      case ($urandom_range(3))
        0: txt[pos] = 8'($urandom_range(255));
        1: txt.insert(pos, CH_DOT);
        // stray letter: unknown or overlong units, letters inside amounts
        2: txt.insert(pos, 8'(8'h61 + $urandom_range(25)));
        default: begin
          while (txt.size() > pos + 1) void'(txt.pop_back());
        end
      endcase
    end
    foreach (txt[i]) send_item(txt[i], 1'b0);
    send_item(8'($urandom_range(255)), 1'b1);
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned rx_pct);
    send_idle_pct = send_pct;
    stall_pct     = rx_pct;
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // nothing but the end item, then whitespace only
  task automatic test_empty_text();
    send_text("");
    send_text(" \t");
  endtask

  // dot outranks a malformed term
  task automatic test_status_priority();
    send_text("1x.");
  endtask

  // gap before a unit, trailing blank, three- and two-letter units
  task automatic test_well_formed();
    send_text("5 mon\t3ms");
  endtask

  // digits with no unit
  task automatic test_malformed_term();
    send_text("7");
  endtask

  // each term fits but the sum saturates
  task automatic test_total_overflow();
    send_text("200000y200000y");
  endtask

  // random texts through every idling phase
  task automatic test_random_texts();
    int unsigned mark;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       set_idling(0, 0);
        1:       set_idling(66, 0);
        2:       set_idling(0, 66);
        default: set_idling(36, 36);
      endcase
      mark = chars_sent;
      while (chars_sent - mark < PHASE_CHARS) send_random_text(25);
    end
  endtask

  // raw bytes over the whole code range, biased toward digits now and then
  task automatic test_noise_bytes();
    set_idling(36, 36);
    repeat (10) begin
      repeat ($urandom_range(3, 10)) begin
        if ($urandom_range(3) == 0) send_item(8'(8'h30 + $urandom_range(9)), 1'b0);
        else send_item(8'($urandom_range(255)), 1'b0);
      end
      send_item(8'($urandom_range(255)), 1'b1);
    end
  endtask

  // receiver holds off while texts keep coming, so a second end item must stall
  task automatic test_backpressure();
    set_idling(0, 0);
    hold_request = 1'b1;
    @(negedge clk);
    repeat (4) send_random_text(0);
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_char_code  = '0;
    in_is_end     = 1'b0;
    send_idle_pct = 0;
    stall_pct     = 0;
    chars_sent    = 0;
    fail_count    = 0;
    quiet_cycles  = 0;
    hold_request  = 1'b0;
    clear_parser();

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_text();
    test_status_priority();
    test_well_formed();
    test_malformed_term();
    test_total_overflow();
    test_random_texts();
    test_noise_bytes();
    test_backpressure();
    test_random_texts();

    // let every owed duration come out, then allow a little extra
    sender_idle();
    set_idling(0, 0);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== duration_text_parser.f =====
src/dtp_pkg.sv
src/duration_text_parser.sv
verif/tb_top.sv
